// File: sv/ncf_pkg.sv
// Shared types, constants and sequencer states of the negative cycle finder.
package ncf_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 32;
	localparam int unsigned MAX_EDGES_DEF    = 256;
	localparam int unsigned VERTEX_W         = 6;
	localparam int unsigned WEIGHT_W         = 32;
	localparam int unsigned DIST_W           = 64;
	localparam int unsigned CYCLE_DEPTH      = 64;
	localparam int unsigned CYCLE_AW         = 6;
	localparam int unsigned VCOUNT_RESET     = 32;
	localparam logic [DIST_W-1:0] DIST_INIT  = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic [VERTEX_W-1:0]        edge_from;
		logic [VERTEX_W-1:0]        edge_to;
		logic signed [WEIGHT_W-1:0] edge_weight;
		logic                       last_edge;
	} edge_item_t;

	typedef struct packed {
		logic                found;
		logic [VERTEX_W-1:0] cycle_vertex;
		logic                last_result;
	} result_item_t;

	// One stored edge as kept in the edge memory.
	typedef struct packed {
		logic [VERTEX_W-1:0]        from_v;
		logic [VERTEX_W-1:0]        to_v;
		logic signed [WEIGHT_W-1:0] weight;
	} edge_rec_t;

	typedef struct packed {
		logic              better;
		logic [DIST_W-1:0] cand;
	} relax_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_EDGE,
		ST_DIST,
		ST_RELAX,
		ST_DECIDE,
		ST_PRD,
		ST_PDATA,
		ST_CWR,
		ST_CRD,
		ST_ERD,
		ST_EOUT
	} state_t;

endpackage

// File: sv/ncf_ram.sv
// Single write port, single read port memory with a registered read.
module ncf_ram #(
	parameter int unsigned WIDTH = ncf_pkg::VERTEX_W,
	parameter int unsigned DEPTH = ncf_pkg::CYCLE_DEPTH
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/ncf_relax_unit.sv
// Shared relaxation unit: one 64-bit add of the edge weight and one signed compare.
module ncf_relax_unit (
	input  logic [ncf_pkg::DIST_W-1:0]          dist_from,
	input  logic [ncf_pkg::DIST_W-1:0]          dist_to,
	input  logic signed [ncf_pkg::WEIGHT_W-1:0] weight,
	input  logic [ncf_pkg::VERTEX_W-1:0]        from_v,
	input  logic [ncf_pkg::VERTEX_W-1:0]        to_v,
	input  logic [ncf_pkg::VERTEX_W-1:0]        vcount,
	output ncf_pkg::relax_res_t                 res
);

	logic [ncf_pkg::DIST_W-1:0] wext;
	logic                       in_range;

	always_comb begin
		wext       = {{(ncf_pkg::DIST_W - ncf_pkg::WEIGHT_W){weight[ncf_pkg::WEIGHT_W-1]}},
			weight};
		in_range   = (from_v <= vcount) && (to_v <= vcount);
		res.cand   = dist_from + wext;
		res.better = in_range && ($signed(dist_to) > $signed(res.cand));
	end

endmodule

// File: sv/negative_cycle_finder.sv
// Top level: edge store, Bellman-Ford sequencer, parent walk and cycle output.
//
// Channel  | Direction | Handshake               | Beat contents
// item     | in        | start, busy             | edge_from, edge_to, edge_weight, last_edge
// result   | out       | result_strobe           | found, cycle_vertex, last_result
// cfg      | in        | cfg_valid, cfg_ready    | vertex_count
//
// Each edge beat is taken while start is high and the block is idle. The beat marked last
// starts a search that keeps busy high through the relaxation rounds and, when a cycle is
// found, through the walk and output of that cycle; the one relaxation unit handles one edge
// at a time, through the edge read, distance read and relax states.
// Reset clears the sequencer, the edge count and sets the vertex count to 32.
// Results leave one per strobe, and strobes are never back to back; the receiver cannot stall.
module negative_cycle_finder #(
	parameter int unsigned MAX_VERTICES = ncf_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_EDGES    = ncf_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ncf_pkg::edge_item_t         item,
	output logic                        result_strobe,
	output ncf_pkg::result_item_t       result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ncf_pkg::VERTEX_W-1:0] cfg_data
);

	localparam int unsigned NSLOTS = MAX_VERTICES + 1;
	localparam int unsigned VW     = $clog2(NSLOTS);
	localparam int unsigned AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned ETW    = $clog2(MAX_EDGES + 1);
	localparam int unsigned EREC_W = $bits(ncf_pkg::edge_rec_t);
	localparam int unsigned VTX_W  = ncf_pkg::VERTEX_W;
	localparam int unsigned CAW    = ncf_pkg::CYCLE_AW;

	ncf_pkg::state_t state_q, state_d;

	logic [VTX_W-1:0] vertex_count_q;
	logic [VTX_W-1:0] n_q;
	logic [ETW-1:0]   total_q;
	logic [AW-1:0]    e_q;
	logic [VTX_W-1:0] r_q;
	logic [VW-1:0]    i_q;
	logic             relaxed_q;
	logic [VTX_W-1:0] last_q;
	logic [VTX_W-1:0] v_q;
	logic [VTX_W-1:0] k_q;
	logic [VTX_W-1:0] w_q;
	logic [VTX_W-1:0] start_v_q;
	logic [CAW:0]     cnt_q;
	logic [CAW-1:0]   idx_q;

	// Memory ports
	logic                      edge_we, edge_re;
	ncf_pkg::edge_rec_t        edge_wrec, edge_rrec;
	logic                      dist_we, dist_re;
	logic [VW-1:0]             dist_waddr;
	logic [ncf_pkg::DIST_W-1:0] dist_wdata, dist_from_rd, dist_to_rd;
	logic                      par_we, par_re;
	logic [VW-1:0]             par_waddr, par_raddr;
	logic [VTX_W-1:0]          par_wdata, par_rdata;
	logic                      buf_we, buf_re;
	logic [VTX_W-1:0]          buf_rdata;

	ncf_pkg::relax_res_t       rel;

	logic                      store_ok, e_last, round_last, cyc_done;
	logic [VTX_W-1:0]          n_eff;
	logic [ncf_pkg::DIST_W-1:0] dist_init;

	logic                      emit;
	ncf_pkg::result_item_t     emit_item;

	assign busy      = (state_q != ncf_pkg::ST_IDLE);
	assign cfg_ready = (state_q == ncf_pkg::ST_IDLE);

	assign store_ok   = (total_q < ETW'(MAX_EDGES));
	assign e_last     = (ETW'(e_q) == total_q - 1'b1);
	assign round_last = (r_q == n_q - 1'b1);
	assign cyc_done   = ((w_q == start_v_q) && (cnt_q != '0)) ||
		(cnt_q == (CAW + 1)'(ncf_pkg::CYCLE_DEPTH - 1));
	assign n_eff      = (vertex_count_q > VTX_W'(MAX_VERTICES)) ?
		VTX_W'(MAX_VERTICES) : vertex_count_q;

	// Distance slot 0 always starts at zero, slot 1 only when it is a vertex of the graph.
	assign dist_init = ((i_q == VW'(0)) || ((i_q == VW'(1)) && (n_q != '0))) ?
		'0 : ncf_pkg::DIST_INIT;

	assign edge_wrec.from_v = item.edge_from;
	assign edge_wrec.to_v   = item.edge_to;
	assign edge_wrec.weight = item.edge_weight;

	assign dist_waddr = (state_q == ncf_pkg::ST_INIT) ? i_q : edge_rrec.to_v[VW-1:0];
	assign dist_wdata = (state_q == ncf_pkg::ST_INIT) ? dist_init : rel.cand;
	assign par_waddr  = dist_waddr;
	assign par_wdata  = (state_q == ncf_pkg::ST_INIT) ? '0 : edge_rrec.from_v;

	ncf_ram #(.WIDTH(EREC_W), .DEPTH(MAX_EDGES)) u_edge_mem (
		.clk   (clk),
		.we    (edge_we),
		.waddr (total_q[AW-1:0]),
		.wdata (edge_wrec),
		.re    (edge_re),
		.raddr (e_q),
		.rdata (edge_rrec)
	);

	// The distance store is kept twice so that both ends of an edge are read together.
	ncf_ram #(.WIDTH(ncf_pkg::DIST_W), .DEPTH(NSLOTS)) u_dist_from (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.re    (dist_re),
		.raddr (edge_rrec.from_v[VW-1:0]),
		.rdata (dist_from_rd)
	);

	ncf_ram #(.WIDTH(ncf_pkg::DIST_W), .DEPTH(NSLOTS)) u_dist_to (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.re    (dist_re),
		.raddr (edge_rrec.to_v[VW-1:0]),
		.rdata (dist_to_rd)
	);

	ncf_ram #(.WIDTH(VTX_W), .DEPTH(NSLOTS)) u_parent (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.re    (par_re),
		.raddr (par_raddr),
		.rdata (par_rdata)
	);

	ncf_ram #(.WIDTH(VTX_W), .DEPTH(ncf_pkg::CYCLE_DEPTH)) u_cycle_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[CAW-1:0]),
		.wdata (w_q),
		.re    (buf_re),
		.raddr (idx_q),
		.rdata (buf_rdata)
	);

	ncf_relax_unit u_relax (
		.dist_from (dist_from_rd),
		.dist_to   (dist_to_rd),
		.weight    (edge_rrec.weight),
		.from_v    (edge_rrec.from_v),
		.to_v      (edge_rrec.to_v),
		.vcount    (n_q),
		.res       (rel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		edge_we   = 1'b0;
		edge_re   = 1'b0;
		dist_we   = 1'b0;
		dist_re   = 1'b0;
		par_we    = 1'b0;
		par_re    = 1'b0;
		par_raddr = v_q[VW-1:0];
		buf_we    = 1'b0;
		buf_re    = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		case (state_q)
			ncf_pkg::ST_IDLE: begin
				if (start) begin
					edge_we = store_ok;
					if (item.last_edge) begin
						state_d = ncf_pkg::ST_INIT;
					end
				end
			end
			ncf_pkg::ST_INIT: begin
				dist_we = 1'b1;
				par_we  = 1'b1;
				if (i_q == VW'(NSLOTS - 1)) begin
					state_d = ((n_q == '0) || (total_q == '0)) ?
						ncf_pkg::ST_DECIDE : ncf_pkg::ST_EDGE;
				end
			end
			ncf_pkg::ST_EDGE: begin
				edge_re = 1'b1;
				state_d = ncf_pkg::ST_DIST;
			end
			ncf_pkg::ST_DIST: begin
				dist_re = 1'b1;
				state_d = ncf_pkg::ST_RELAX;
			end
			ncf_pkg::ST_RELAX: begin
				dist_we = rel.better;
				par_we  = rel.better;
				state_d = (e_last && round_last) ? ncf_pkg::ST_DECIDE : ncf_pkg::ST_EDGE;
			end
			ncf_pkg::ST_DECIDE: begin
				if (!relaxed_q) begin
					emit                  = 1'b1;
					emit_item.last_result = 1'b1;
					state_d               = ncf_pkg::ST_IDLE;
				end else begin
					state_d = ncf_pkg::ST_PRD;
				end
			end
			ncf_pkg::ST_PRD: begin
				par_re  = 1'b1;
				state_d = ncf_pkg::ST_PDATA;
			end
			ncf_pkg::ST_PDATA: begin
				state_d = (k_q == n_q - 1'b1) ? ncf_pkg::ST_CWR : ncf_pkg::ST_PRD;
			end
			ncf_pkg::ST_CWR: begin
				buf_we = 1'b1;
				if (cyc_done) begin
					state_d = ncf_pkg::ST_ERD;
				end else begin
					par_re    = 1'b1;
					par_raddr = w_q[VW-1:0];
					state_d   = ncf_pkg::ST_CRD;
				end
			end
			ncf_pkg::ST_CRD: begin
				state_d = ncf_pkg::ST_CWR;
			end
			ncf_pkg::ST_ERD: begin
				buf_re  = 1'b1;
				state_d = ncf_pkg::ST_EOUT;
			end
			ncf_pkg::ST_EOUT: begin
				emit                   = 1'b1;
				emit_item.found        = 1'b1;
				emit_item.cycle_vertex = buf_rdata;
				emit_item.last_result  = (idx_q == '0);
				state_d = (idx_q == '0) ? ncf_pkg::ST_IDLE : ncf_pkg::ST_ERD;
			end
			default: begin
				state_d = ncf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VTX_W'(ncf_pkg::VCOUNT_RESET);
			total_q        <= '0;
			n_q            <= '0;
			e_q            <= '0;
			r_q            <= '0;
			i_q            <= '0;
			relaxed_q      <= 1'b0;
			last_q         <= '0;
			v_q            <= '0;
			k_q            <= '0;
			w_q            <= '0;
			start_v_q      <= '0;
			cnt_q          <= '0;
			idx_q          <= '0;
			result_strobe  <= 1'b0;
		end else begin
			result_strobe <= emit;
			if (cfg_valid && cfg_ready) begin
				vertex_count_q <= cfg_data;
			end
			case (state_q)
				ncf_pkg::ST_IDLE: begin
					if (start) begin
						if (store_ok) begin
							total_q <= total_q + 1'b1;
						end
						n_q       <= n_eff;
						i_q       <= '0;
						e_q       <= '0;
						r_q       <= '0;
						relaxed_q <= 1'b0;
						last_q    <= '0;
					end
				end
				ncf_pkg::ST_INIT: begin
					i_q <= i_q + 1'b1;
				end
				ncf_pkg::ST_RELAX: begin
					if (rel.better) begin
						last_q <= edge_rrec.to_v;
					end
					// Only the final round's relaxations decide the outcome.
					if (e_last && !round_last) begin
						relaxed_q <= 1'b0;
					end else if (rel.better) begin
						relaxed_q <= 1'b1;
					end
					if (e_last) begin
						e_q <= '0;
						if (!round_last) begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						e_q <= e_q + 1'b1;
					end
				end
				ncf_pkg::ST_DECIDE: begin
					total_q <= '0;
					v_q     <= last_q;
					k_q     <= '0;
				end
				ncf_pkg::ST_PDATA: begin
					v_q       <= par_rdata;
					k_q       <= k_q + 1'b1;
					w_q       <= par_rdata;
					start_v_q <= par_rdata;
					cnt_q     <= '0;
				end
				ncf_pkg::ST_CWR: begin
					cnt_q <= cnt_q + 1'b1;
					idx_q <= cnt_q[CAW-1:0];
				end
				ncf_pkg::ST_CRD: begin
					w_q <= par_rdata;
				end
				ncf_pkg::ST_EOUT: begin
					idx_q <= idx_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result <= emit_item;
		end
	end

	a_notfound_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.found) |-> (result.last_result && result.cycle_vertex == '0))
		else $error("not-found result must be a single final beat with vertex zero");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ETW'(MAX_EDGES))
		else $error("edge count exceeds the edge store");

	a_relax_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ncf_pkg::ST_RELAX && rel.better) |->
		(edge_rrec.from_v <= n_q && edge_rrec.to_v <= n_q))
		else $error("relaxation through a vertex beyond the vertex count");

	// The final beat leaves an idle block, so a new graph may start while it is out.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last_result) |-> (!busy ##1 !result_strobe))
		else $error("results continue after the final beat of a run");

endmodule

// File: verif/negative_cycle_finder_tb.sv
// Self-checking testbench for the negative cycle finder: edge beats in, cycle beats checked.
`timescale 1ns / 1ps
module negative_cycle_finder_tb;

	localparam int unsigned DIR_ROWS       = 15;
	localparam int unsigned TOTAL_ITEMS    = 310;
	localparam int unsigned OVERFLOW_EDGES = ncf_pkg::MAX_EDGES_DEF + 2;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned SOURCE_VTX     = 1;
	localparam ncf_pkg::result_item_t NO_CYCLE =
		'{found: 1'b0, cycle_vertex: '0, last_result: 1'b1};

	typedef struct packed {
		bit                           cfg_en;
		logic [ncf_pkg::VERTEX_W-1:0] cfg_v;
		ncf_pkg::edge_item_t          beat;
		bit                           typed;
		ncf_pkg::result_item_t        typed_res;
	} dir_row_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         start     = 1'b0;
	ncf_pkg::edge_item_t          item      = '0;
	logic                         cfg_valid = 1'b0;
	logic [ncf_pkg::VERTEX_W-1:0] cfg_data  = '0;
	logic                         busy;
	logic                         result_strobe;
	logic                         cfg_ready;
	ncf_pkg::result_item_t        result;

	logic [ncf_pkg::VERTEX_W-1:0] vertex_count_now = ncf_pkg::VERTEX_W'(ncf_pkg::VCOUNT_RESET);
	ncf_pkg::edge_rec_t           graph_edges [ncf_pkg::MAX_EDGES_DEF];
	int unsigned                  graph_edge_cnt = 0;
	logic [ncf_pkg::DIST_W-1:0]   dist_now [ncf_pkg::MAX_VERTICES_DEF+1];
	logic [ncf_pkg::VERTEX_W-1:0] parent_now [ncf_pkg::MAX_VERTICES_DEF+1];
	logic [ncf_pkg::VERTEX_W-1:0] walk_buf [ncf_pkg::CYCLE_DEPTH];
	ncf_pkg::result_item_t        cycle_beats_due [$];
	ncf_pkg::result_item_t        due_beat;
	ncf_pkg::edge_item_t          draft [64];
	logic [ncf_pkg::VERTEX_W-1:0] ring [6];
	dir_row_t                     dir_rows [DIR_ROWS];

	int unsigned errors = 0, edges_sent = 0, graphs_run = 0;
	int unsigned beats_seen = 0, cycles_seen = 0, burst_left = 0;
	bit          gaps_on = 1'b0;

	negative_cycle_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Appends one expected result beat at the tail of the queue.
	function void queue_due(input ncf_pkg::result_item_t due);
		cycle_beats_due.insert(cycle_beats_due.size(), due);
	endfunction

	// Bellman-Ford over the stored edges, then the parent walk; queues the expected beats if asked.
	function void relax_and_walk(input bit queue_beats);
		int unsigned n, r, e, i, cnt;
		logic [ncf_pkg::VERTEX_W-1:0] a, b, v, w, last_v;
		logic [ncf_pkg::DIST_W-1:0] cand;
		bit relaxed, closed;
		ncf_pkg::result_item_t beat;
		n = (vertex_count_now > ncf_pkg::MAX_VERTICES_DEF) ? ncf_pkg::MAX_VERTICES_DEF :
			vertex_count_now;
		for (i = 0; i <= ncf_pkg::MAX_VERTICES_DEF; i++) begin
			dist_now[i] = ncf_pkg::DIST_INIT;
			parent_now[i] = '0;
		end
		dist_now[0] = '0;
		if (SOURCE_VTX <= n) begin
			dist_now[SOURCE_VTX] = '0;
		end
		last_v = '0;
		relaxed = 1'b0;
		for (r = 0; r < n; r++) begin
			relaxed = 1'b0;
			for (e = 0; e < graph_edge_cnt; e++) begin
				a = graph_edges[e].from_v;
				b = graph_edges[e].to_v;
				if (a <= n && b <= n) begin
					cand = dist_now[a] +
						{{(ncf_pkg::DIST_W-ncf_pkg::WEIGHT_W)
						{graph_edges[e].weight[ncf_pkg::WEIGHT_W-1]}},
						graph_edges[e].weight};
					if ($signed(dist_now[b]) > $signed(cand)) begin
						parent_now[b] = a;
						dist_now[b] = cand;
						last_v = b;
						relaxed = 1'b1;
					end
				end
			end
		end
		graph_edge_cnt = 0;
		if (!relaxed) begin
			if (queue_beats) begin
				queue_due(NO_CYCLE);
			end
			return;
		end
		// Stepping back n parents lands on the cycle, unless the walk never closes.
		v = last_v;
		for (i = 0; i < n; i++) begin
			v = parent_now[v];
		end
		cnt = 0;
		w = v;
		closed = 1'b0;
		while (cnt < ncf_pkg::CYCLE_DEPTH && !closed) begin
			walk_buf[cnt] = w;
			cnt++;
			if (w == v && cnt > 1) begin
				closed = 1'b1;
			end else begin
				w = parent_now[w];
			end
		end
		if (queue_beats) begin
			for (i = 0; i < cnt; i++) begin
				beat.found = 1'b1;
				beat.cycle_vertex = walk_buf[cnt-1-i];
				beat.last_result = (i + 1 == cnt);
				queue_due(beat);
			end
		end
	endfunction

	function dir_row_t mk_row(input bit cfg_en, input int unsigned cfg_v,
			input int unsigned from_v, input int unsigned to_v, input logic [31:0] w,
			input bit last, input bit typed, input ncf_pkg::result_item_t typed_res);
		dir_row_t row;
		row.cfg_en = cfg_en;
		row.cfg_v = ncf_pkg::VERTEX_W'(cfg_v);
		row.beat.edge_from = ncf_pkg::VERTEX_W'(from_v);
		row.beat.edge_to = ncf_pkg::VERTEX_W'(to_v);
		row.beat.edge_weight = w;
		row.beat.last_edge = last;
		row.typed = typed;
		row.typed_res = typed_res;
		return row;
	endfunction

	function logic [ncf_pkg::VERTEX_W-1:0] pick_vcount();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 12) return ncf_pkg::VERTEX_W'($urandom_range(2, 6));
		if (roll < 15) return ncf_pkg::VERTEX_W'($urandom_range(0, 1));
		if (roll < 18) return ncf_pkg::VERTEX_W'($urandom_range(7, 63));
		return (roll == 18) ? ncf_pkg::VERTEX_W'(ncf_pkg::MAX_VERTICES_DEF) : '1;
	endfunction

	function logic [ncf_pkg::VERTEX_W-1:0] rand_vertex(input int unsigned hi);
		if ($urandom_range(0, 7) != 0) return ncf_pkg::VERTEX_W'($urandom_range(0, hi));
		return ncf_pkg::VERTEX_W'($urandom_range(0, 63));
	endfunction

	// Holds start high until the beat is taken, then updates the shadow edge store.
	task automatic send_edge(input ncf_pkg::edge_item_t beat, input bit typed,
			input ncf_pkg::result_item_t typed_res);
		if (gaps_on && burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		start <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		edges_sent++;
		if (graph_edge_cnt < ncf_pkg::MAX_EDGES_DEF) begin
			graph_edges[graph_edge_cnt] = '{from_v: beat.edge_from, to_v: beat.edge_to,
				weight: beat.edge_weight};
			graph_edge_cnt++;
		end
		if (beat.last_edge) begin
			graphs_run++;
			relax_and_walk(!typed);
			if (typed) begin
				queue_due(typed_res);
			end
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (cycle_beats_due.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vcount(input logic [ncf_pkg::VERTEX_W-1:0] count);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		vertex_count_now = count;
	endtask

	task automatic random_graph();
		int unsigned n_eff, hi, k, n_edges, base, i, j;
		gaps_on = ($urandom_range(0, 3) != 0);
		n_eff = (vertex_count_now > ncf_pkg::MAX_VERTICES_DEF) ? ncf_pkg::MAX_VERTICES_DEF :
			vertex_count_now;
		hi = (n_eff == 0) ? 1 : n_eff;
		n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
		for (i = 0; i < n_edges; i++) begin
			draft[i].edge_from = rand_vertex(hi);
			draft[i].edge_to = rand_vertex(hi);
			if ($urandom_range(0, 3) == 0) begin
				draft[i].edge_weight = $urandom;
			end else begin
				draft[i].edge_weight = ncf_pkg::WEIGHT_W'(int'($urandom_range(0, 40)) - 20);
			end
			draft[i].last_edge = 1'b0;
		end
		// Most graphs carry a short ring whose weights lean negative.
		if ($urandom_range(0, 3) != 0) begin
			k = $urandom_range(1, (hi < 5) ? hi : 5);
			if (k > n_edges) begin
				k = n_edges;
			end
			for (j = 0; j < k; j++) begin
				ring[j] = ncf_pkg::VERTEX_W'($urandom_range(0, hi));
			end
			base = $urandom_range(0, n_edges - k);
			for (j = 0; j < k; j++) begin
				draft[base+j].edge_from = ring[j];
				draft[base+j].edge_to = ring[(j + 1) % k];
				draft[base+j].edge_weight = ncf_pkg::WEIGHT_W'(int'($urandom_range(0, 10)) - 7);
			end
		end
		draft[n_edges-1].last_edge = 1'b1;
		for (i = 0; i < n_edges; i++) begin
			send_edge(draft[i], 1'b0, NO_CYCLE);
		end
	endtask

	// Results are taken at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			beats_seen++;
			if (cycle_beats_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected cycle beat found=%0b vertex=%0d last=%0b", $time,
					result.found, result.cycle_vertex, result.last_result);
			end else begin
				due_beat = cycle_beats_due.pop_front();
				if (result.found !== due_beat.found) begin
					errors++;
					$display("%0t: found expected %0b got %0b", $time, due_beat.found,
						result.found);
				end
				if (result.cycle_vertex !== due_beat.cycle_vertex) begin
					errors++;
					$display("%0t: cycle_vertex expected %0d got %0d", $time,
						due_beat.cycle_vertex, result.cycle_vertex);
				end
				if (result.last_result !== due_beat.last_result) begin
					errors++;
					$display("%0t: last_result expected %0b got %0b", $time,
						due_beat.last_result, result.last_result);
				end
				if (due_beat.found && due_beat.last_result) begin
					cycles_seen++;
				end
			end
		end
	end

	initial begin
		int unsigned k;
		ncf_pkg::edge_item_t beat;
		// Reset count first, then loops through vertex 0, skipped vertices, zero and one.
		dir_rows[0]  = mk_row(1'b0, 0, 1, 2, 5, 1'b1, 1'b1, NO_CYCLE);
		dir_rows[1]  = mk_row(1'b0, 0, 0, 0, 32'h8000_0000, 1'b1, 1'b0, NO_CYCLE);
		dir_rows[2]  = mk_row(1'b0, 0, 2, 3, 1, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[3]  = mk_row(1'b0, 0, 3, 4, -3, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[4]  = mk_row(1'b0, 0, 4, 2, 1, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[5]  = mk_row(1'b0, 0, 1, 2, 7, 1'b1, 1'b0, NO_CYCLE);
		dir_rows[6]  = mk_row(1'b1, 3, 63, 63, -1, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[7]  = mk_row(1'b0, 0, 4, 2, -7, 1'b1, 1'b1, NO_CYCLE);
		dir_rows[8]  = mk_row(1'b1, 0, 1, 1, -1, 1'b1, 1'b1, NO_CYCLE);
		dir_rows[9]  = mk_row(1'b1, 63, 1, 32, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[10] = mk_row(1'b0, 0, 32, 33, -1, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[11] = mk_row(1'b0, 0, 5, 5, -1, 1'b1, 1'b0, NO_CYCLE);
		dir_rows[12] = mk_row(1'b1, 1, 1, 1, 32'h7FFF_FFFF, 1'b1, 1'b1, NO_CYCLE);
		dir_rows[13] = mk_row(1'b1, 2, 1, 2, -1, 1'b0, 1'b0, NO_CYCLE);
		dir_rows[14] = mk_row(1'b0, 0, 2, 1, -1, 1'b1, 1'b0, NO_CYCLE);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			if (dir_rows[k].cfg_en) begin
				wait_idle();
				write_vcount(dir_rows[k].cfg_v);
			end
			send_edge(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].typed_res);
		end

		// The full-store graph below takes most of the item budget.
		while (edges_sent + OVERFLOW_EDGES < TOTAL_ITEMS) begin
			if ($urandom_range(0, 1) == 0) begin
				wait_idle();
				write_vcount(pick_vcount());
			end else if ($urandom_range(0, 4) == 0) begin
				wait_idle();
			end
			random_graph();
		end

		// Fill the store past capacity; the dropped tail is a negative loop that must not count.
		wait_idle();
		write_vcount(ncf_pkg::VERTEX_W'(3));
		gaps_on = 1'b1;
		for (k = 0; k < OVERFLOW_EDGES; k++) begin
			beat.edge_from = ncf_pkg::VERTEX_W'($urandom_range(0, 4));
			beat.edge_to = ncf_pkg::VERTEX_W'($urandom_range(0, 4));
			beat.edge_weight = ncf_pkg::WEIGHT_W'($urandom_range(0, 20));
			beat.last_edge = (k == OVERFLOW_EDGES - 1);
			if (k >= ncf_pkg::MAX_EDGES_DEF) begin
				beat.edge_from = ncf_pkg::VERTEX_W'(2);
				beat.edge_to = ncf_pkg::VERTEX_W'(2);
				beat.edge_weight = -5;
			end
			send_edge(beat, 1'b0, NO_CYCLE);
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d graphs from %0d edge beats, vertex counts 0 to 63 and a full store.",
			graphs_run, edges_sent);
		$display("Checked %0d result beats; %0d negative cycles reported.", beats_seen,
			cycles_seen);
		if (errors == 0) begin
			$display("negative_cycle_finder regression: pass");
		end else begin
			$display("negative_cycle_finder regression: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timed out with %0d cycle beats still due.", cycle_beats_due.size());
		$display("negative_cycle_finder regression: fail");
		$finish;
	end

endmodule
